// ===== hdl/assert_macros.svh =====
// Assertion macros used by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks an implication whose consequent holds in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/jhmp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package jhmp_pkg;

  localparam int COUNT_WIDTH_DEF = 20;
  localparam int HDR_WIDTH = 20;
  localparam logic [HDR_WIDTH-1:0] HDR_MAX = 20'hFFFFF;

  typedef enum logic [15:0] {
    PH_SOI0     = 16'h0001,
    PH_SOI1     = 16'h0002,
    PH_MARK0    = 16'h0004,
    PH_MARK1    = 16'h0008,
    PH_LEN0     = 16'h0010,
    PH_LEN1     = 16'h0020,
    PH_SKIP     = 16'h0040,
    PH_APP0     = 16'h0080,
    PH_APP1     = 16'h0100,
    PH_DQT_HEAD = 16'h0200,
    PH_DQT_VAL  = 16'h0400,
    PH_DHT_HEAD = 16'h0800,
    PH_DHT_CNT  = 16'h1000,
    PH_DHT_SYM  = 16'h2000,
    PH_SOF0     = 16'h4000,
    PH_SOS      = 16'h8000
  } phase_t;

  localparam logic [2:0] REC_QUANT    = 3'd0;
  localparam logic [2:0] REC_HUF_CNT  = 3'd1;
  localparam logic [2:0] REC_HUF_SYM  = 3'd2;
  localparam logic [2:0] REC_FRAME    = 3'd3;
  localparam logic [2:0] REC_SCAN     = 3'd4;
  localparam logic [2:0] REC_APP1     = 3'd5;
  localparam logic [2:0] REC_FINISHED = 3'd6;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_NO_SOI    = 4'd1;
  localparam logic [3:0] ST_FORMAT    = 4'd2;
  localparam logic [3:0] ST_APP0_ID   = 4'd3;
  localparam logic [3:0] ST_DQT_PREC  = 4'd4;
  localparam logic [3:0] ST_SOF_PREC  = 4'd5;
  localparam logic [3:0] ST_SOF_COMP  = 4'd6;
  localparam logic [3:0] ST_DRI       = 4'd7;
  localparam logic [3:0] ST_SOS_COMP  = 4'd8;
  localparam logic [3:0] ST_SOF_UNSUP = 4'd9;
  localparam logic [3:0] ST_EOI       = 4'd10;
  localparam logic [3:0] ST_NO_SOS    = 4'd11;
  localparam logic [3:0] ST_TRUNC     = 4'd12;

  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] MK_DRI    = 8'hDD;
  localparam logic [7:0] MK_APP0   = 8'hE0;
  localparam logic [7:0] MK_APP1   = 8'hE1;
  localparam logic [7:0] MK_DQT    = 8'hDB;
  localparam logic [7:0] MK_DHT    = 8'hC4;
  localparam logic [7:0] MK_SOF0   = 8'hC0;
  localparam logic [7:0] MK_SOS    = 8'hDA;

  typedef struct packed {
    logic [2:0]  record;
    logic        table_class;
    logic [3:0]  table_id;
    logic [7:0]  entry_index;
    logic [7:0]  entry_value;
    logic [3:0]  factor_h;
    logic [3:0]  factor_v;
    logic [15:0] image_height;
    logic [15:0] image_width;
    logic [3:0]  status;
    logic [19:0] header_bytes;
  } rec_t;

  function automatic rec_t rec_make(logic [2:0] rec, logic cls, logic [3:0] id,
                                    logic [7:0] idx, logic [7:0] val,
                                    logic [3:0] fh, logic [3:0] fv);
    rec_t r;
    r = '0;
    r.record = rec;
    r.table_class = cls;
    r.table_id = id;
    r.entry_index = idx;
    r.entry_value = val;
    r.factor_h = fh;
    r.factor_v = fv;
    return r;
  endfunction

  function automatic logic [7:0] jfif_char(logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0: c = 8'h4A;
      3'd1: c = 8'h46;
      3'd2: c = 8'h49;
      3'd3: c = 8'h46;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/jpeg_header_marker_parser.sv =====
// JPEG header marker parser.
// Input channel: in_byte and last_byte with in_valid and in_stall; one file
// byte is taken per word, and last_byte marks the final byte of the data.
// Output channel: one record per word on the record fields, with out_valid
// and out_stall. A byte gives at most two records.
// Each accepted byte is decoded in the cycle it is taken and its records are
// written to a four-entry output queue; with the queue empty, the first record
// is visible on the output in the cycle after the byte is accepted.
// Throughput is one byte per cycle while in_stall is low. in_stall rises
// when fewer than two queue entries are free, so a stalled receiver holds
// back the input once three records are waiting; records are never dropped.
// After the finished record the parser ignores further bytes until reset.
// Reset (synchronous, active high) empties the queue and re-arms the parser
// to expect the SOI marker.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module jpeg_header_marker_parser #(
  parameter int COUNT_WIDTH = jhmp_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       record,
  output logic             table_class,
  output logic [3:0]       table_id,
  output logic [7:0]       entry_index,
  output logic [7:0]       entry_value,
  output logic [3:0]       factor_h,
  output logic [3:0]       factor_v,
  output logic [15:0]      image_height,
  output logic [15:0]      image_width,
  output logic [3:0]       status,
  output logic [19:0]      header_bytes
);

  localparam int DEPTH = 4;
  localparam int PW = $clog2(DEPTH);

  jhmp_pkg::phase_t phase, phase_next, body_kind, kind_next;
  logic [15:0] seg_rem, seg_rem_next, seg_pos, seg_pos_next;
  logic [7:0]  sub_counter, sub_next, symbol_total, total_next;
  logic [7:0]  component_id, comp_next;
  logic [4:0]  current_table, table_next;
  logic [15:0] saved_height, height_next, saved_width, width_next;
  logic [COUNT_WIDTH-1:0] byte_count, cnt_inc;
  logic        stopped, stopped_next;
  logic        fin;
  logic [3:0]  fin_status;
  logic [1:0]  n_rec;
  jhmp_pkg::rec_t rec_a, rec_b, rec_x;
  logic [32:0] cnt_ext;
  logic [19:0] hdr;
  logic        accept, pop;
  logic [1:0]  push_n;

  jhmp_pkg::rec_t fifo [DEPTH];
  logic [PW-1:0] wp, rp;
  logic [PW:0]   count;

  assign accept = in_valid && !in_stall;
  assign pop = out_valid && !out_stall;
  assign in_stall = count > (PW+1)'(DEPTH - 2);
  assign out_valid = count != '0;
  assign push_n = (accept && !stopped) ? n_rec : 2'd0;

  assign cnt_inc = (byte_count == '1) ? byte_count : byte_count + COUNT_WIDTH'(1);
  assign cnt_ext = 33'(cnt_inc);
  assign hdr = (cnt_ext > 33'(jhmp_pkg::HDR_MAX)) ? jhmp_pkg::HDR_MAX : cnt_ext[19:0];

  always_comb begin
    phase_next = phase;
    kind_next = body_kind;
    seg_rem_next = seg_rem;
    seg_pos_next = seg_pos;
    sub_next = sub_counter;
    total_next = symbol_total;
    comp_next = component_id;
    table_next = current_table;
    height_next = saved_height;
    width_next = saved_width;
    fin = 1'b0;
    fin_status = jhmp_pkg::ST_OK;
    rec_a = '0;
    rec_b = '0;
    rec_x = '0;
    n_rec = 2'd0;
    unique case (phase)
      jhmp_pkg::PH_SOI0: begin
        if (in_byte != jhmp_pkg::MK_PREFIX) begin
          fin = 1'b1;
          fin_status = jhmp_pkg::ST_NO_SOI;
        end else begin
          phase_next = jhmp_pkg::PH_SOI1;
        end
      end
      jhmp_pkg::PH_SOI1: begin
        if (in_byte != jhmp_pkg::MK_SOI) begin
          fin = 1'b1;
          fin_status = jhmp_pkg::ST_NO_SOI;
        end else begin
          phase_next = jhmp_pkg::PH_MARK0;
        end
      end
      jhmp_pkg::PH_MARK0: begin
        if (in_byte != jhmp_pkg::MK_PREFIX) begin
          fin = 1'b1;
          fin_status = jhmp_pkg::ST_FORMAT;
        end else begin
          phase_next = jhmp_pkg::PH_MARK1;
        end
      end
      jhmp_pkg::PH_MARK1: begin
        case (in_byte) inside
          jhmp_pkg::MK_PREFIX: ;
          [8'hD0:8'hD7]: phase_next = jhmp_pkg::PH_MARK0;
          jhmp_pkg::MK_EOI: begin
            fin = 1'b1;
            fin_status = jhmp_pkg::ST_EOI;
          end
          jhmp_pkg::MK_DRI: begin
            fin = 1'b1;
            fin_status = jhmp_pkg::ST_DRI;
          end
          [8'hC1:8'hC3], [8'hC5:8'hCB], [8'hCD:8'hCF], 8'hF7, 8'hF8: begin
            fin = 1'b1;
            fin_status = jhmp_pkg::ST_SOF_UNSUP;
          end
          default: begin
            phase_next = jhmp_pkg::PH_LEN0;
            case (in_byte)
              jhmp_pkg::MK_APP0: kind_next = jhmp_pkg::PH_APP0;
              jhmp_pkg::MK_APP1: begin
                kind_next = jhmp_pkg::PH_APP1;
                if (!last_byte) begin
                  rec_a = jhmp_pkg::rec_make(jhmp_pkg::REC_APP1, 1'b0, 4'd0, 8'd0,
                                             jhmp_pkg::MK_PREFIX, 4'd0, 4'd0);
                  rec_b = jhmp_pkg::rec_make(jhmp_pkg::REC_APP1, 1'b0, 4'd0, 8'd1,
                                             in_byte, 4'd0, 4'd0);
                  n_rec = 2'd2;
                end
              end
              jhmp_pkg::MK_DQT:  kind_next = jhmp_pkg::PH_DQT_HEAD;
              jhmp_pkg::MK_DHT:  kind_next = jhmp_pkg::PH_DHT_HEAD;
              jhmp_pkg::MK_SOF0: kind_next = jhmp_pkg::PH_SOF0;
              jhmp_pkg::MK_SOS:  kind_next = jhmp_pkg::PH_SOS;
              default:           kind_next = jhmp_pkg::PH_SKIP;
            endcase
          end
        endcase
      end
      jhmp_pkg::PH_LEN0: begin
        if (body_kind == jhmp_pkg::PH_APP1) begin
          rec_a = jhmp_pkg::rec_make(jhmp_pkg::REC_APP1, 1'b0, 4'd0, 8'd2, in_byte,
                                     4'd0, 4'd0);
          n_rec = 2'd1;
        end
        seg_rem_next = {in_byte, 8'h00};
        phase_next = jhmp_pkg::PH_LEN1;
      end
      jhmp_pkg::PH_LEN1: begin
        if (body_kind == jhmp_pkg::PH_APP1) begin
          rec_a = jhmp_pkg::rec_make(jhmp_pkg::REC_APP1, 1'b0, 4'd0, 8'd3, in_byte,
                                     4'd0, 4'd0);
          n_rec = 2'd1;
        end
        seg_rem_next = ({seg_rem[15:8], in_byte} >= 16'd2) ?
                       {seg_rem[15:8], in_byte} - 16'd2 : 16'd0;
        seg_pos_next = 16'd0;
        phase_next = body_kind;
      end
      default: begin
        seg_rem_next = seg_rem - 16'd1;
        case (phase)
          jhmp_pkg::PH_APP0: begin
            if (seg_pos < 16'd5 && in_byte != jhmp_pkg::jfif_char(seg_pos[2:0])) begin
              fin = 1'b1;
              fin_status = jhmp_pkg::ST_APP0_ID;
            end
          end
          jhmp_pkg::PH_APP1: begin
            rec_a = jhmp_pkg::rec_make(jhmp_pkg::REC_APP1, 1'b0, 4'd0,
                                       seg_pos[7:0] + 8'd4, in_byte, 4'd0, 4'd0);
            n_rec = 2'd1;
          end
          jhmp_pkg::PH_DQT_HEAD: begin
            if (in_byte[7:4] != 4'd0) begin
              fin = 1'b1;
              fin_status = jhmp_pkg::ST_DQT_PREC;
            end else begin
              table_next = {1'b0, in_byte[3:0]};
              sub_next = 8'd0;
              phase_next = jhmp_pkg::PH_DQT_VAL;
            end
          end
          jhmp_pkg::PH_DQT_VAL: begin
            rec_a = jhmp_pkg::rec_make(jhmp_pkg::REC_QUANT, 1'b0, current_table[3:0],
                                       sub_counter, in_byte, 4'd0, 4'd0);
            n_rec = 2'd1;
            sub_next = sub_counter + 8'd1;
            if (sub_next >= 8'd64) phase_next = jhmp_pkg::PH_DQT_HEAD;
          end
          jhmp_pkg::PH_DHT_HEAD: begin
            table_next = {in_byte[7:4] != 4'd0, in_byte[3:0]};
            sub_next = 8'd0;
            total_next = 8'd0;
            phase_next = jhmp_pkg::PH_DHT_CNT;
          end
          jhmp_pkg::PH_DHT_CNT: begin
            rec_a = jhmp_pkg::rec_make(jhmp_pkg::REC_HUF_CNT, current_table[4],
                                       current_table[3:0], sub_counter, in_byte,
                                       4'd0, 4'd0);
            n_rec = 2'd1;
            total_next = symbol_total + in_byte;
            sub_next = sub_counter + 8'd1;
            if (sub_next >= 8'd16) begin
              sub_next = 8'd0;
              phase_next = (total_next != 8'd0) ? jhmp_pkg::PH_DHT_SYM :
                                                  jhmp_pkg::PH_DHT_HEAD;
            end
          end
          jhmp_pkg::PH_DHT_SYM: begin
            rec_a = jhmp_pkg::rec_make(jhmp_pkg::REC_HUF_SYM, current_table[4],
                                       current_table[3:0], sub_counter, in_byte,
                                       4'd0, 4'd0);
            n_rec = 2'd1;
            sub_next = sub_counter + 8'd1;
            if (sub_next >= symbol_total) phase_next = jhmp_pkg::PH_DHT_HEAD;
          end
          jhmp_pkg::PH_SOF0: begin
            if (seg_pos[15:4] == 12'd0) begin
              case (seg_pos[3:0])
                4'd0: begin
                  if (in_byte != 8'd8) begin
                    fin = 1'b1;
                    fin_status = jhmp_pkg::ST_SOF_PREC;
                  end
                end
                4'd1: height_next = {in_byte, saved_height[7:0]};
                4'd2: height_next = {saved_height[15:8], in_byte};
                4'd3: width_next = {in_byte, saved_width[7:0]};
                4'd4: width_next = {saved_width[15:8], in_byte};
                4'd5: begin
                  if (in_byte != 8'd3) begin
                    fin = 1'b1;
                    fin_status = jhmp_pkg::ST_SOF_COMP;
                  end
                end
                4'd6, 4'd9, 4'd12: comp_next = in_byte;
                4'd7, 4'd10, 4'd13: sub_next = in_byte;
                4'd8, 4'd11, 4'd14: begin
                  rec_a = jhmp_pkg::rec_make(jhmp_pkg::REC_FRAME, 1'b0, 4'd0,
                                             component_id, in_byte,
                                             sub_counter[7:4], sub_counter[3:0]);
                  n_rec = 2'd1;
                end
                default: ;
              endcase
            end
          end
          jhmp_pkg::PH_SOS: begin
            if (seg_pos == 16'd0) begin
              if (in_byte != 8'd3) begin
                fin = 1'b1;
                fin_status = jhmp_pkg::ST_SOS_COMP;
              end
            end else if (seg_pos <= 16'd6) begin
              if (seg_pos[0]) begin
                comp_next = in_byte;
              end else begin
                rec_a = jhmp_pkg::rec_make(jhmp_pkg::REC_SCAN, 1'b0, 4'd0,
                                           component_id, 8'd0,
                                           in_byte[7:4], in_byte[3:0]);
                n_rec = 2'd1;
              end
            end
          end
          default: ;
        endcase
        seg_pos_next = seg_pos + 16'd1;
      end
    endcase

    // Segment end, after the length bytes or after a body byte.
    if (!fin && seg_rem_next == 16'd0 &&
        (phase == jhmp_pkg::PH_LEN1 || phase == jhmp_pkg::PH_SKIP ||
         phase == jhmp_pkg::PH_APP0 || phase == jhmp_pkg::PH_APP1 ||
         phase == jhmp_pkg::PH_DQT_HEAD || phase == jhmp_pkg::PH_DQT_VAL ||
         phase == jhmp_pkg::PH_DHT_HEAD || phase == jhmp_pkg::PH_DHT_CNT ||
         phase == jhmp_pkg::PH_DHT_SYM || phase == jhmp_pkg::PH_SOF0 ||
         phase == jhmp_pkg::PH_SOS)) begin
      if (phase_next == jhmp_pkg::PH_APP0 && seg_pos_next < 16'd5) begin
        fin = 1'b1;
        fin_status = jhmp_pkg::ST_APP0_ID;
      end else if (phase_next == jhmp_pkg::PH_SOS) begin
        fin = 1'b1;
        fin_status = jhmp_pkg::ST_OK;
      end else begin
        phase_next = jhmp_pkg::PH_MARK0;
      end
    end

    if (!fin && last_byte) begin
      fin = 1'b1;
      fin_status = (phase_next == jhmp_pkg::PH_MARK0) ? jhmp_pkg::ST_NO_SOS :
                                                        jhmp_pkg::ST_TRUNC;
    end

    if (fin) begin
      rec_x = '0;
      rec_x.record = jhmp_pkg::REC_FINISHED;
      rec_x.image_height = height_next;
      rec_x.image_width = width_next;
      rec_x.status = fin_status;
      rec_x.header_bytes = hdr;
      if (n_rec == 2'd0) begin
        rec_a = rec_x;
      end else begin
        rec_b = rec_x;
      end
      n_rec = n_rec + 2'd1;
    end
    stopped_next = stopped || fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= jhmp_pkg::PH_SOI0;
      body_kind <= jhmp_pkg::PH_SKIP;
      seg_rem <= '0;
      seg_pos <= '0;
      sub_counter <= '0;
      symbol_total <= '0;
      component_id <= '0;
      current_table <= '0;
      saved_height <= '0;
      saved_width <= '0;
      byte_count <= '0;
      stopped <= 1'b0;
    end else if (accept && !stopped) begin
      phase <= phase_next;
      body_kind <= kind_next;
      seg_rem <= seg_rem_next;
      seg_pos <= seg_pos_next;
      sub_counter <= sub_next;
      symbol_total <= total_next;
      component_id <= comp_next;
      current_table <= table_next;
      saved_height <= height_next;
      saved_width <= width_next;
      byte_count <= cnt_inc;
      stopped <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      wp <= wp + PW'(push_n);
      if (pop) rp <= rp + PW'(1);
      count <= count + (PW+1)'(push_n) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) fifo[wp] <= rec_a;
    if (push_n == 2'd2) fifo[wp + PW'(1)] <= rec_b;
  end

  assign record = fifo[rp].record;
  assign table_class = fifo[rp].table_class;
  assign table_id = fifo[rp].table_id;
  assign entry_index = fifo[rp].entry_index;
  assign entry_value = fifo[rp].entry_value;
  assign factor_h = fifo[rp].factor_h;
  assign factor_v = fifo[rp].factor_v;
  assign image_height = fifo[rp].image_height;
  assign image_width = fifo[rp].image_width;
  assign status = fifo[rp].status;
  assign header_bytes = fifo[rp].header_bytes;

  `ASSERT_CLK(a_count_bound, clk, rst, count <= (PW+1)'(DEPTH), "queue overflow")
  `ASSERT_NEXT(a_stop_holds, clk, rst, stopped, stopped, "parser re-armed without reset")
  `ASSERT_NEXT(a_silent_after, clk, rst, stopped && !pop, count == $past(count),
               "records after finish")
  `ASSERT_CLK(a_finish_rec, clk, rst, (accept && !stopped && stopped_next) |-> (n_rec != 2'd0),
              "finish without record")

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;

  class record_scoreboard;
    jhmp_pkg::rec_t    pending[$];
    int      errors;
    jhmp_pkg::phase_t  ph;
    jhmp_pkg::phase_t  kind;
    int      seg_left;
    int      seg_pos;
    int      sub;
    int      tbl;
    int      sym_total;
    int      comp;
    int      height;
    int      width;
    longint  byte_cnt;
    bit      done;

    function new();
      errors = 0;
      ph = jhmp_pkg::PH_SOI0;
      kind = jhmp_pkg::PH_SKIP;
      seg_left = 0;
      seg_pos = 0;
      sub = 0;
      tbl = 0;
      sym_total = 0;
      comp = 0;
      height = 0;
      width = 0;
      byte_cnt = 0;
      done = 0;
    endfunction

    function void emit(logic [2:0] rec, int cls, int id, int idx, int val, int fh, int fv);
      jhmp_pkg::rec_t r;
      r = '0;
      r.record = rec;
      r.table_class = cls[0];
      r.table_id = id[3:0];
      r.entry_index = idx[7:0];
      r.entry_value = val[7:0];
      r.factor_h = fh[3:0];
      r.factor_v = fv[3:0];
      pending.push_back(r);
    endfunction

    function void stop(logic [3:0] st);
      jhmp_pkg::rec_t r;
      r = '0;
      r.record = jhmp_pkg::REC_FINISHED;
      r.image_height = height[15:0];
      r.image_width = width[15:0];
      r.status = st;
      r.header_bytes = (byte_cnt > jhmp_pkg::HDR_MAX) ? jhmp_pkg::HDR_MAX : byte_cnt[19:0];
      pending.push_back(r);
      done = 1;
    endfunction

    function void close_segment();
      if (ph == jhmp_pkg::PH_APP0 && seg_pos < 5) stop(jhmp_pkg::ST_APP0_ID);
      else if (ph == jhmp_pkg::PH_SOS) stop(jhmp_pkg::ST_OK);
      else ph = jhmp_pkg::PH_MARK0;
    endfunction

    function bit sof_unsupported(logic [7:0] m);
      return (m >= 8'hC1 && m <= 8'hC3) || (m >= 8'hC5 && m <= 8'hCB) ||
             (m >= 8'hCD && m <= 8'hCF) || m == 8'hF7 || m == 8'hF8;
    endfunction

    function void body(logic [7:0] b);
      int p;
      int k;
      logic [7:0] id_char;
      p = seg_pos;
      seg_left = (seg_left - 1) & 16'hFFFF;
      case (ph)
        jhmp_pkg::PH_APP0: begin
          case (p)
            0: id_char = 8'h4A;
            1: id_char = 8'h46;
            2: id_char = 8'h49;
            3: id_char = 8'h46;
            default: id_char = 8'h00;
          endcase
          if (p < 5 && b != id_char) stop(jhmp_pkg::ST_APP0_ID);
        end
        jhmp_pkg::PH_APP1: emit(jhmp_pkg::REC_APP1, 0, 0, p + 4, b, 0, 0);
        jhmp_pkg::PH_DQT_HEAD: begin
          if (b[7:4] != 0) stop(jhmp_pkg::ST_DQT_PREC);
          else begin
            tbl = b[3:0];
            sub = 0;
            ph = jhmp_pkg::PH_DQT_VAL;
          end
        end
        jhmp_pkg::PH_DQT_VAL: begin
          emit(jhmp_pkg::REC_QUANT, 0, tbl, sub, b, 0, 0);
          sub++;
          if (sub >= 64) ph = jhmp_pkg::PH_DQT_HEAD;
        end
        jhmp_pkg::PH_DHT_HEAD: begin
          tbl = ((b[7:4] != 0) ? 16 : 0) | b[3:0];
          sub = 0;
          sym_total = 0;
          ph = jhmp_pkg::PH_DHT_CNT;
        end
        jhmp_pkg::PH_DHT_CNT: begin
          emit(jhmp_pkg::REC_HUF_CNT, tbl >> 4, tbl, sub, b, 0, 0);
          sym_total = (sym_total + b) & 8'hFF;
          sub++;
          if (sub >= 16) begin
            sub = 0;
            ph = (sym_total != 0) ? jhmp_pkg::PH_DHT_SYM : jhmp_pkg::PH_DHT_HEAD;
          end
        end
        jhmp_pkg::PH_DHT_SYM: begin
          emit(jhmp_pkg::REC_HUF_SYM, tbl >> 4, tbl, sub, b, 0, 0);
          sub++;
          if (sub >= sym_total) ph = jhmp_pkg::PH_DHT_HEAD;
        end
        jhmp_pkg::PH_SOF0: begin
          if (p == 0) begin
            if (b != 8'd8) stop(jhmp_pkg::ST_SOF_PREC);
          end else if (p == 1) height = (height & 8'hFF) | (b << 8);
          else if (p == 2) height = (height & 16'hFF00) | b;
          else if (p == 3) width = (width & 8'hFF) | (b << 8);
          else if (p == 4) width = (width & 16'hFF00) | b;
          else if (p == 5) begin
            if (b != 8'd3) stop(jhmp_pkg::ST_SOF_COMP);
          end else if (p <= 14) begin
            k = (p - 6) % 3;
            if (k == 0) comp = b;
            else if (k == 1) sub = b;
            else emit(jhmp_pkg::REC_FRAME, 0, 0, comp, b, sub >> 4, sub & 15);
          end
        end
        jhmp_pkg::PH_SOS: begin
          if (p == 0) begin
            if (b != 8'd3) stop(jhmp_pkg::ST_SOS_COMP);
          end else if (p <= 6) begin
            if (p[0]) comp = b;
            else emit(jhmp_pkg::REC_SCAN, 0, 0, comp, 0, b[7:4], b[3:0]);
          end
        end
        default: ;
      endcase
      seg_pos = (p + 1) & 16'hFFFF;
      if (!done && seg_left == 0) close_segment();
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      int len;
      if (done) return;
      if (byte_cnt < (64'd1 << jhmp_pkg::COUNT_WIDTH_DEF) - 1) byte_cnt++;
      case (ph)
        jhmp_pkg::PH_SOI0:
          if (b != jhmp_pkg::MK_PREFIX) stop(jhmp_pkg::ST_NO_SOI);
          else ph = jhmp_pkg::PH_SOI1;
        jhmp_pkg::PH_SOI1:
          if (b != jhmp_pkg::MK_SOI) stop(jhmp_pkg::ST_NO_SOI);
          else ph = jhmp_pkg::PH_MARK0;
        jhmp_pkg::PH_MARK0:
          if (b != jhmp_pkg::MK_PREFIX) stop(jhmp_pkg::ST_FORMAT);
          else ph = jhmp_pkg::PH_MARK1;
        jhmp_pkg::PH_MARK1: begin
          if (b == jhmp_pkg::MK_PREFIX) ;
          else if (b >= 8'hD0 && b <= 8'hD7) ph = jhmp_pkg::PH_MARK0;
          else if (b == jhmp_pkg::MK_EOI) stop(jhmp_pkg::ST_EOI);
          else if (b == jhmp_pkg::MK_DRI) stop(jhmp_pkg::ST_DRI);
          else if (sof_unsupported(b)) stop(jhmp_pkg::ST_SOF_UNSUP);
          else begin
            if (b == jhmp_pkg::MK_APP0) kind = jhmp_pkg::PH_APP0;
            else if (b == jhmp_pkg::MK_APP1) begin
              kind = jhmp_pkg::PH_APP1;
              if (!last) begin
                emit(jhmp_pkg::REC_APP1, 0, 0, 0, 8'hFF, 0, 0);
                emit(jhmp_pkg::REC_APP1, 0, 0, 1, b, 0, 0);
              end
            end else if (b == jhmp_pkg::MK_DQT) kind = jhmp_pkg::PH_DQT_HEAD;
            else if (b == jhmp_pkg::MK_DHT) kind = jhmp_pkg::PH_DHT_HEAD;
            else if (b == jhmp_pkg::MK_SOF0) kind = jhmp_pkg::PH_SOF0;
            else if (b == jhmp_pkg::MK_SOS) kind = jhmp_pkg::PH_SOS;
            else kind = jhmp_pkg::PH_SKIP;
            ph = jhmp_pkg::PH_LEN0;
          end
        end
        jhmp_pkg::PH_LEN0: begin
          if (kind == jhmp_pkg::PH_APP1) emit(jhmp_pkg::REC_APP1, 0, 0, 2, b, 0, 0);
          seg_left = b << 8;
          ph = jhmp_pkg::PH_LEN1;
        end
        jhmp_pkg::PH_LEN1: begin
          if (kind == jhmp_pkg::PH_APP1) emit(jhmp_pkg::REC_APP1, 0, 0, 3, b, 0, 0);
          len = (seg_left & 16'hFF00) | b;
          seg_left = (len >= 2) ? len - 2 : 0;
          seg_pos = 0;
          ph = kind;
          if (seg_left == 0) close_segment();
        end
        default: body(b);
      endcase
      if (!done && last)
        stop((ph == jhmp_pkg::PH_MARK0) ? jhmp_pkg::ST_NO_SOS : jhmp_pkg::ST_TRUNC);
    endfunction

    function void check(jhmp_pkg::rec_t got);
      jhmp_pkg::rec_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected record, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: record mismatch, expected %p, actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  record;
  logic        table_class;
  logic [3:0]  table_id;
  logic [7:0]  entry_index;
  logic [7:0]  entry_value;
  logic [3:0]  factor_h;
  logic [3:0]  factor_v;
  logic [15:0] image_height;
  logic [15:0] image_width;
  logic [3:0]  status;
  logic [19:0] header_bytes;

  jpeg_header_marker_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_byte(in_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .record(record), .table_class(table_class), .table_id(table_id),
    .entry_index(entry_index), .entry_value(entry_value),
    .factor_h(factor_h), .factor_v(factor_v),
    .image_height(image_height), .image_width(image_width),
    .status(status), .header_bytes(header_bytes)
  );

  record_scoreboard sb = new();
  logic [7:0] file_bytes[$];
  logic       file_last[$];
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int quiet_cycles;

  initial begin
    clk = 0;
    rst = 1;
    in_valid = 0;
    in_byte = 0;
    last_byte = 0;
    out_stall = 0;
    send_idle_pct = 23;
    recv_idle_pct = 86;
    hold_cycles = 0;
    quiet_cycles = 0;
  end

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_byte(in_byte, last_byte);
      if (out_valid && !out_stall) begin
        jhmp_pkg::rec_t got;
        got.record = record;
        got.table_class = table_class;
        got.table_id = table_id;
        got.entry_index = entry_index;
        got.entry_value = entry_value;
        got.factor_h = factor_h;
        got.factor_v = factor_v;
        got.image_height = image_height;
        got.image_width = image_width;
        got.status = status;
        got.header_bytes = header_bytes;
        sb.check(got);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic add(logic [7:0] b);
    file_bytes.push_back(b);
    file_last.push_back(1'b0);
  endtask

  task automatic add_len(int len);
    add(len[15:8]);
    add(len[7:0]);
  endtask

  task automatic add_random(int n);
    repeat (n) add($urandom_range(255));
  endtask

  task automatic add_marker(logic [7:0] m);
    add(jhmp_pkg::MK_PREFIX);
    if ($urandom_range(9) == 0) repeat ($urandom_range(3, 1)) add(jhmp_pkg::MK_PREFIX);
    add(m);
  endtask

  task automatic add_sof0(bit good_prec, bit good_comps);
    add_marker(jhmp_pkg::MK_SOF0);
    add_len(17);
    add(good_prec ? 8'd8 : 8'd12);
    add_random(4);
    add(good_comps ? 8'd3 : 8'd1);
    add_random(9);
  endtask

  task automatic add_sos(bit good);
    add_marker(jhmp_pkg::MK_SOS);
    add_len(12);
    add(good ? 8'd3 : 8'd4);
    add_random(9);
  endtask

  task automatic add_segment(int kind);
    int len;
    int n;
    int counts[16];
    int total;
    case (kind)
      0: begin
        add_marker(jhmp_pkg::MK_APP1);
        len = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(40, 2);
        add_len(len);
        if (len > 2) add_random(len - 2);
      end
      1: begin
        n = $urandom_range(2, 1);
        len = 2 + 65 * n;
        add_marker(jhmp_pkg::MK_DQT);
        if ($urandom_range(4) == 0) len = $urandom_range(len - 1, 3);
        add_len(len);
        for (int t = 0; t < n; t++) begin
          add({4'h0, 4'($urandom_range(15))});
          for (int i = 0; i < 64; i++)
            add((i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(255)));
        end
        for (int i = len; i < 2 + 65 * n; i++) begin
          file_bytes.pop_back();
          file_last.pop_back();
        end
      end
      2: begin
        total = 0;
        foreach (counts[i]) begin
          counts[i] = ($urandom_range(3) == 0) ? $urandom_range(3) : 0;
          total += counts[i];
        end
        add_marker(jhmp_pkg::MK_DHT);
        add_len(2 + 17 + total);
        add({3'b000, 1'($urandom_range(1)), 4'($urandom_range(15))});
        foreach (counts[i]) add(counts[i]);
        add_random(total);
      end
      3: add_sof0(1, 1);
      4: begin
        add_marker($urandom_range(1) ? 8'($urandom_range(8'hEF, 8'hE2)) : 8'hFE);
        add_len($urandom_range(12, 2));
        file_bytes = file_bytes[0:$-2];
        file_last = file_last[0:$-2];
        len = $urandom_range(12, 2);
        add_len(len);
        add_random(len - 2);
      end
      5: add_marker(8'($urandom_range(8'hD7, 8'hD0)));
      default: begin
        add_marker(jhmp_pkg::MK_APP0);
        add_len(16);
        add(8'h4A); add(8'h46); add(8'h49); add(8'h46); add(8'h00);
        add_random(9);
      end
    endcase
  endtask

  task automatic build_file(int target);
    int ending;
    ending = $urandom_range(13);
    add(jhmp_pkg::MK_PREFIX);
    add((ending == 13) ? 8'h00 : jhmp_pkg::MK_SOI);
    add_segment(6);
    for (int k = 0; k <= 5; k++) add_segment(k);
    while (file_bytes.size() < target) add_segment($urandom_range(6));
    case (ending)
      0: add_sos(1);
      1: add_marker(jhmp_pkg::MK_EOI);
      2: add_marker(jhmp_pkg::MK_DRI);
      3: add_marker(8'hC2);
      4: add_sof0(0, 1);
      5: add_sof0(1, 0);
      6: add_sos(0);
      7: begin
        add_marker(jhmp_pkg::MK_DQT);
        add_len(67);
        add(8'h10);
        add_random(64);
      end
      8: ;
      9: begin
        add_marker(jhmp_pkg::MK_APP1);
        add_len(30);
        add_random(5);
      end
      10: begin
        add_marker(jhmp_pkg::MK_APP0);
        add_len(8);
        add(8'h4A); add(8'h46); add(8'h58);
        add_random(3);
      end
      11: add(8'h12);
      12: add_marker(jhmp_pkg::MK_APP1);
      default: ;
    endcase
    if (ending >= 8 || $urandom_range(1)) file_last[$] = 1'b1;
    repeat (8) begin
      add($urandom_range(255));
      file_last.push_back($urandom_range(1));
      file_last.delete(file_last.size() - 2);
    end
  endtask

  task automatic send_byte(logic [7:0] b, logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    last_byte <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    int n;
    build_file(1530);
    n = file_bytes.size();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) begin
        send_idle_pct = 86;
        recv_idle_pct = 23;
      end
      if (i == 2 * n / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        in_valid <= 1'b0;
        @(negedge clk);
        hold_cycles = 300;
        @(posedge clk);
      end
      send_byte(file_bytes[i], file_last[i]);
    end
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
